FILE: rtl/core/dmc_pkg.sv
package dmc_pkg;

  // Field widths fixed by the item format
  localparam int ADDR_W    = 16;
  localparam int WOFF_W    = 4;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 32;
  localparam int TOTAL_W   = 13;
  localparam int BLKW_W    = 5;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int TAG_W     = 16;

  // Shared divider: 16-bit operands, two quotient bits per cycle
  localparam int DIV_W     = 16;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [TOTAL_W-1:0] TOTAL_RST = 13'd256;
  localparam logic [BLKW_W-1:0]  BLKW_RST  = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_WORDS = 1'b0,
    CFG_BLOCK_WORDS = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIV_GEOM = 2'd0,
    DIV_ADDR = 2'd1,
    DIV_QUO  = 2'd2
  } div_src_e;

  typedef struct packed {
    op_e                      operation;
    logic [ADDR_W-1:0]        address;
    logic [WOFF_W-1:0]        word_offset;
    logic signed [DATA_W-1:0] fill_data;
  } dmc_in_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]         hit_total;
    logic [CNT_W-1:0]         miss_total;
  } dmc_out_t;

  typedef struct packed {
    logic     item_ld;
    logic     div_start;
    div_src_e div_src;
    logic     geom_ld;
    logic     off_ld;
    logic     mem_go;
    logic     rsp_ld;
  } dmc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dmc_sts_t;

endpackage

FILE: rtl/core/dmc_div.sv
module dmc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dmc_pkg::DIV_W-1:0]  dividend_i,
  input  logic [dmc_pkg::DIV_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [dmc_pkg::DIV_W-1:0]  quo_o,
  output logic [dmc_pkg::DIV_W-1:0]  rem_o
);
  import dmc_pkg::*;

  logic [DIV_W-1:0]     rem_q, quo_q, dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_W:0]       st1, st2;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] r,
                                              input logic b,
                                              input logic [DIV_W-1:0] d);
    logic [DIV_W:0] t;
    logic [DIV_W:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, s[DIV_W-1:0]};
    end else begin
      div_step = {1'b0, t[DIV_W-1:0]};
    end
  endfunction

  always_comb begin
    st1 = div_step(rem_q, quo_q[DIV_W-1], dsr_q);
    st2 = div_step(st1[DIV_W-1:0], quo_q[DIV_W-2], dsr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= st2[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-3:0], st1[DIV_W], st2[DIV_W]};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/core/dmc_dpath.sv
module dmc_dpath #(
  parameter int MAX_BLOCKS      = 256,
  parameter int MAX_BLOCK_WORDS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dmc_pkg::dmc_cmd_t             cmd_i,
  output dmc_pkg::dmc_sts_t             sts_o,
  input  dmc_pkg::dmc_in_t              in_data_i,
  input  logic                          cfg_we_i,
  input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmc_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dmc_pkg::dmc_out_t             out_data_o
);
  import dmc_pkg::*;

  localparam int DEPTH = MAX_BLOCKS * MAX_BLOCK_WORDS;
  localparam int DA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int OFF_W = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
  localparam int BE_W  = $clog2(MAX_BLOCK_WORDS + 1);
  localparam int BK_W  = $clog2(MAX_BLOCKS + 1);

  logic [TOTAL_W-1:0] total_q;
  logic [BLKW_W-1:0]  block_q;
  logic [BE_W-1:0]    b_eff;
  logic [BK_W-1:0]    blk_q;

  dmc_in_t            item_q;
  logic [OFF_W-1:0]   off_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TAG_W-1:0]   tag_q;
  logic [TAG_W-1:0]   tag_rd_q;
  logic [DATA_W-1:0]  data_rd_q;

  logic [TAG_W-1:0]   tag_mem [MAX_BLOCKS];
  logic [DATA_W-1:0]  data_mem [DEPTH];
  logic [MAX_BLOCKS-1:0] valid_q;

  logic [CNT_W-1:0]   hit_cnt_q, miss_cnt_q, hit_cnt_d, miss_cnt_d;
  logic               out_valid_q;
  dmc_out_t           out_q;

  logic               div_done;
  logic [DIV_W-1:0]   div_quo, div_rem, dvd, dsr;
  logic [IDX_W-1:0]   idx_w;
  logic [DA_W-1:0]    base_w, rd_addr, wr_addr;
  logic               wo_ok, is_fill, hit_w;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
      block_q <= BLKW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TOTAL_WORDS: total_q <= cfg_data_i;
        CFG_BLOCK_WORDS: block_q <= cfg_data_i[BLKW_W-1:0];
      endcase
    end
  end

  // Effective block size: zero counts as one, clamp to the largest block
  always_comb begin
    if (block_q == '0) begin
      b_eff = BE_W'(1);
    end else if (32'(block_q) > MAX_BLOCK_WORDS) begin
      b_eff = BE_W'(MAX_BLOCK_WORDS);
    end else begin
      b_eff = BE_W'(block_q);
    end
  end

  always_comb begin
    unique case (cmd_i.div_src)
      DIV_GEOM: begin
        dvd = DIV_W'(total_q);
        dsr = DIV_W'(b_eff);
      end
      DIV_ADDR: begin
        dvd = DIV_W'(in_data_i.address);
        dsr = DIV_W'(b_eff);
      end
      DIV_QUO: begin
        dvd = div_quo;
        dsr = DIV_W'(blk_q);
      end
      default: begin
        dvd = '0;
        dsr = '0;
      end
    endcase
  end

  dmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dsr),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Block count from the geometry divide, held in range; item and offset latches
  always_ff @(posedge clk_i) begin
    if (cmd_i.geom_ld) begin
      if (div_quo == '0) begin
        blk_q <= BK_W'(1);
      end else if (32'(div_quo) > MAX_BLOCKS) begin
        blk_q <= BK_W'(MAX_BLOCKS);
      end else begin
        blk_q <= BK_W'(div_quo);
      end
    end
    if (cmd_i.item_ld) begin
      item_q <= in_data_i;
    end
    if (cmd_i.off_ld) begin
      off_q <= div_rem[OFF_W-1:0];
    end
  end

  assign is_fill = (item_q.operation == OP_FILL);
  assign idx_w   = div_rem[IDX_W-1:0];
  assign base_w  = DA_W'(idx_w) * DA_W'(MAX_BLOCK_WORDS);
  assign rd_addr = base_w + DA_W'(off_q);
  assign wr_addr = base_w + DA_W'(item_q.word_offset);
  assign wo_ok   = ({{BE_W{1'b0}}, item_q.word_offset} < {{WOFF_W{1'b0}}, b_eff});

  // Tag store: read and write at the index from the second divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_go) begin
      idx_q    <= idx_w;
      tag_q    <= div_quo;
      tag_rd_q <= tag_mem[idx_w];
      if (is_fill) begin
        tag_mem[idx_w] <= div_quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_go) begin
      data_rd_q <= data_mem[rd_addr];
      if (is_fill && wo_ok) begin
        data_mem[wr_addr] <= item_q.fill_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.mem_go && is_fill) begin
      valid_q[idx_w] <= 1'b1;
    end
  end

  assign hit_w = !is_fill && valid_q[idx_q] && (tag_rd_q == tag_q);

  // Saturating event counters
  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (!is_fill) begin
      if (hit_w) begin
        if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + 1'b1;
      end else begin
        if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rsp_ld) begin
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_ld) begin
      out_q.hit        <= hit_w;
      out_q.read_data  <= hit_w ? data_rd_q : '0;
      out_q.hit_total  <= hit_cnt_d;
      out_q.miss_total <= miss_cnt_d;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

FILE: rtl/core/dmc_ctrl.sv
module dmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dmc_pkg::dmc_sts_t sts_i,
  output dmc_pkg::dmc_cmd_t cmd_o
);
  import dmc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GEOM = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && !pend_q;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.div_src = DIV_ADDR;
    unique case (state_q)
      S_IDLE: begin
        if (pend_q) begin
          pend_d            = 1'b0;
          cmd_o.div_start   = 1'b1;
          cmd_o.div_src     = DIV_GEOM;
          state_d           = S_GEOM;
        end else if (accept) begin
          cmd_o.item_ld     = 1'b1;
          cmd_o.div_start   = 1'b1;
          cmd_o.div_src     = DIV_ADDR;
          state_d           = S_DIV1;
        end
      end
      S_GEOM: begin
        if (sts_i.div_done) begin
          cmd_o.geom_ld = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.off_ld    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = DIV_QUO;
          state_d         = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts_i.div_done) begin
          cmd_o.mem_go = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.rsp_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // A write always schedules a new geometry pass
    if (cfg_we_i) pend_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

FILE: rtl/core/direct_mapped_cache_lookup_fill_unit.sv
// Direct-mapped cache with lookup and single-word fill. Each input beat is
// either a lookup (operation 0) or the fill of one word of the addressed
// block (operation 1), and each gives exactly one output beat carrying the
// hit flag, the cached word on a hit (zero otherwise) and the saturating hit
// and miss totals. Address split: offset = address mod block size, index =
// (address / block size) mod block count, tag = address / capacity, with the
// block size clamped to 1..MAX_BLOCK_WORDS and the block count to
// 1..MAX_BLOCKS. One item at a time: each item runs one shared
// two-bit-per-cycle divider twice, followed by one registered memory read
// and the response load. After reset and after every configuration write
// the block count is recomputed with the same divider, and in_ready_o
// stays low until that pass is done. A finished result waits in the output
// register while the next beat is accepted. Stored tags, valid bits and
// data survive a geometry change and are read under the new geometry.
module direct_mapped_cache_lookup_fill_unit #(
  parameter int MAX_BLOCKS      = 256,
  parameter int MAX_BLOCK_WORDS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dmc_pkg::dmc_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dmc_pkg::dmc_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmc_pkg::CFG_W-1:0]     cfg_data_i
);
  import dmc_pkg::*;

  dmc_cmd_t cmd;
  dmc_sts_t sts;

  // Sequencer: geometry pass, two divides, memory access, response
  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Config, divider, tag/data stores, counters and output register
  dmc_dpath #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .MAX_BLOCK_WORDS (MAX_BLOCK_WORDS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/core/dmc_checker.sv
module dmc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  dmc_pkg::dmc_out_t             out_data_o,
  input  logic                          cfg_we_i
);
  import dmc_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  // One item in flight: no new beat right after one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // A configuration write forces a geometry pass before the next beat
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input ready right after a configuration write");

  // A hit is always counted
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.hit_total != '0)
    else $error("hit reported with zero hit total");

endmodule

bind direct_mapped_cache_lookup_fill_unit dmc_checker u_dmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i)
);
